// ===== rtl/core/edd_pkg.sv =====
package edd_pkg;

    localparam int EDD_MAX_WORD_LEN = 32;

    localparam int DIST_W = 6;

    typedef enum logic [1:0]
    {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_START  = 2'd2,
        MODE_CAND   = 2'd3
    } edd_mode_t;

    // controller -> datapath
    typedef struct packed
    {
        logic clear;
        logic append;
        logic start;
        logic cand_ok;
        logic cand_drop;
        logic init_step;
        logic prime;
        logic upd_step;
        logic rd_en;
        logic fetch;
        logic load_out;
    } edd_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic ref_empty;
        logic cand_full;
        logic y_at_len;
        logic out_free;
    } edd_status_t;

endpackage

// ===== rtl/core/edit_distance_engine.sv =====
// Levenshtein edit distance between a stored reference word and a streamed
// candidate. tuser carries the mode: clear reference, append a reference
// character, start a comparison, or apply a candidate character; the two
// latter produce one output transfer with the distance over the whole
// reference and the candidate so far, plus a sticky flag for reference or
// candidate characters dropped past the word limit. The single DP column
// sits in a one-write, one-read memory that start and an accepted candidate
// character sweep one entry per cycle. A finished result waits in an output
// register, so the next item is accepted while it is pending; a result that
// finds that register still occupied holds the input off until the
// downstream side takes the older one.
module edit_distance_engine
#(
    parameter int MAX_WORD_LEN = edd_pkg::EDD_MAX_WORD_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] ch
    input  logic [1:0] s_axis_tuser,  // [1:0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [5:0] distance, [6] overflow, [7] zero
);
    import edd_pkg::*;

    edd_cmd_t    cmd;
    edd_status_t status;

    logic [DIST_W-1:0] distance;
    logic              overflow;

    edd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edd_datapath
    #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_distance (distance),
        .out_overflow (overflow)
    );

    assign m_axis_tdata = {1'b0, overflow, distance};

endmodule

// ===== rtl/core/edd_ctrl.sv =====
module edd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_mode,
    output logic                in_ready,
    input  edd_pkg::edd_status_t status,
    output edd_pkg::edd_cmd_t    cmd
);
    import edd_pkg::*;

    typedef enum logic [5:0]
    {
        ST_IDLE   = 6'b000001,
        ST_INIT   = 6'b000010,
        ST_PRIME  = 6'b000100,
        ST_UPD    = 6'b001000,
        ST_FETCH  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (edd_mode_t'(in_mode))
                        MODE_CLEAR:
                            cmd.clear = 1'b1;
                        MODE_APPEND:
                            cmd.append = 1'b1;
                        MODE_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_INIT;
                        end
                        MODE_CAND:
                        begin
                            if (status.cand_full)
                            begin
                                cmd.cand_drop = 1'b1;
                                state_next    = ST_FETCH;
                            end
                            else
                            begin
                                cmd.cand_ok = 1'b1;
                                state_next  = ST_PRIME;
                            end
                        end
                        default:
                            cmd.clear = 1'b1;
                    endcase
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.y_at_len)
                    state_next = ST_FETCH;
            end
            ST_PRIME:
            begin
                cmd.prime = 1'b1;
                if (status.ref_empty)
                    state_next = ST_FETCH;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (status.y_at_len)
                    state_next = ST_FETCH;
                else
                    cmd.rd_en = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                cmd.fetch  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/edd_datapath.sv =====
module edd_datapath
#(
    parameter int MAX_WORD_LEN = edd_pkg::EDD_MAX_WORD_LEN
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              in_ch,
    input  edd_pkg::edd_cmd_t       cmd,
    output edd_pkg::edd_status_t    status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [edd_pkg::DIST_W-1:0] out_distance,
    output logic                    out_overflow
);
    import edd_pkg::*;

    localparam int CW    = $clog2(MAX_WORD_LEN + 1);
    localparam int AW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LW    = $clog2(2 * MAX_WORD_LEN + 1);
    localparam int DEPTH = MAX_WORD_LEN + 1;
    localparam logic [CW-1:0] MAX_L = CW'(MAX_WORD_LEN);

    logic [7:0]    ref_mem [MAX_WORD_LEN];
    logic [LW-1:0] col_mem [DEPTH];
    logic [DEPTH-1:0] col_vld_reg;

    logic [CW-1:0] ref_len_reg;
    logic [CW-1:0] cand_len_reg;
    logic          ovf_reg;
    logic [CW-1:0] y_reg;
    logic [LW-1:0] diag_reg;
    logic [LW-1:0] prev_reg;
    logic [7:0]    ch_reg;

    logic [LW-1:0] rd_col_reg;
    logic          rd_vld_reg;
    logic [7:0]    rd_ch_reg;

    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                out_ovf_reg;

    logic          ref_full;
    logic [LW-1:0] above;
    logic [LW:0]   opt_del;
    logic [LW:0]   opt_ins;
    logic [LW:0]   opt_sub;
    logic [LW:0]   opt_min;
    logic [LW-1:0] new_val;
    logic [CW-1:0] y_inc;
    logic [CW-1:0] rd_addr;
    logic          col_we;
    logic [CW-1:0] col_wa;
    logic [LW-1:0] col_wd;
    logic [LW+DIST_W-1:0] dist_ext;

    assign ref_full = (ref_len_reg == MAX_L);
    assign y_inc    = y_reg + 1'b1;

    assign status.ref_empty = (ref_len_reg == '0);
    assign status.cand_full = (cand_len_reg == MAX_L);
    assign status.y_at_len  = (y_reg == ref_len_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    // entries never written read as zero
    assign above   = rd_vld_reg ? rd_col_reg : '0;
    assign opt_del = {1'b0, above} + 1'b1;
    assign opt_ins = {1'b0, prev_reg} + 1'b1;
    assign opt_sub = {1'b0, diag_reg} + {{LW{1'b0}}, (rd_ch_reg != ch_reg)};

    always_comb
    begin
        opt_min = (opt_del < opt_ins) ? opt_del : opt_ins;
        if (opt_sub < opt_min)
            opt_min = opt_sub;
    end

    // bounded by twice the word limit, so the top bit is never set here
    assign new_val = opt_min[LW-1:0];

    assign rd_addr = cmd.fetch ? ref_len_reg : y_inc;

    always_comb
    begin
        col_we = 1'b0;
        col_wa = '0;
        col_wd = '0;
        if (cmd.clear)
        begin
            col_we = 1'b1;
        end
        else if (cmd.init_step)
        begin
            col_we = 1'b1;
            col_wa = y_reg;
            col_wd = LW'(y_reg);
        end
        else if (cmd.prime)
        begin
            col_we = 1'b1;
            col_wd = LW'(cand_len_reg);
        end
        else if (cmd.upd_step)
        begin
            col_we = 1'b1;
            col_wa = y_reg;
            col_wd = new_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[col_wa] <= col_wd;
        if (cmd.rd_en)
            rd_col_reg <= col_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !ref_full)
            ref_mem[ref_len_reg[AW-1:0]] <= in_ch;
        if (cmd.rd_en)
            rd_ch_reg <= ref_mem[y_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (col_we)
                col_vld_reg[col_wa] <= 1'b1;
            if (cmd.rd_en)
                rd_vld_reg <= col_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg   <= '0;
            cand_len_reg  <= '0;
            ovf_reg       <= 1'b0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                ref_len_reg  <= '0;
                cand_len_reg <= '0;
                ovf_reg      <= 1'b0;
            end
            if (cmd.append)
            begin
                if (ref_full)
                    ovf_reg <= 1'b1;
                else
                    ref_len_reg <= ref_len_reg + 1'b1;
            end
            if (cmd.start)
            begin
                cand_len_reg <= '0;
                y_reg        <= '0;
            end
            if (cmd.cand_ok)
            begin
                cand_len_reg <= cand_len_reg + 1'b1;
                y_reg        <= '0;
            end
            if (cmd.cand_drop)
                ovf_reg <= 1'b1;
            if (cmd.init_step || cmd.prime || cmd.upd_step)
                y_reg <= y_inc;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cand_ok)
            ch_reg <= in_ch;
        if (cmd.prime)
        begin
            diag_reg <= LW'(cand_len_reg - 1'b1);
            prev_reg <= LW'(cand_len_reg);
        end
        if (cmd.upd_step)
        begin
            diag_reg <= above;
            prev_reg <= new_val;
        end
        if (cmd.load_out)
        begin
            out_dist_reg <= dist_ext[DIST_W-1:0];
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign dist_ext = {{DIST_W{1'b0}}, above};

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import edd_pkg::*;

    localparam int WORD_MAX     = EDD_MAX_WORD_LEN;
    localparam int DRAIN_CYCLES = 2 * WORD_MAX + 16;

    typedef struct packed
    {
        logic [5:0] distance;
        logic       overflow;
    } dist_result_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] ch
    logic [1:0] s_axis_tuser  = 2'b00;  // [1:0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [5:0] distance, [6] overflow, [7] zero

    // predictor state
    logic [7:0]   word_chars [WORD_MAX];
    int           word_len;
    int           dist_col [WORD_MAX + 1];
    int           cand_len;
    logic         overflow_seen;
    dist_result_t pending_distances [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int items_sent;
    int results_seen;
    int mismatches;

    edit_distance_engine u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_failure(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     what, results_seen, want, got);
    endtask

    // Single-column DP update, same order as the hardware sweep.
    task automatic predict_distance(input edd_mode_t m, input logic [7:0] c);
        int diag;
        int above;
        int cost;
        int best;
        dist_result_t res;
        case (m)
            MODE_CLEAR:
            begin
                word_len      = 0;
                cand_len      = 0;
                overflow_seen = 1'b0;
                dist_col[0]   = 0;
            end
            MODE_APPEND:
            begin
                if (word_len < WORD_MAX)
                begin
                    word_chars[word_len] = c;
                    word_len++;
                end
                else
                    overflow_seen = 1'b1;
            end
            MODE_START:
            begin
                for (int z = 0; z <= word_len; z++)
                    dist_col[z] = z;
                cand_len = 0;
            end
            default:
            begin
                if (cand_len < WORD_MAX)
                begin
                    cand_len++;
                    diag = cand_len - 1;
                    dist_col[0] = cand_len;
                    for (int y = 1; y <= word_len; y++)
                    begin
                        above = dist_col[y];
                        cost  = (word_chars[y - 1] == c) ? 0 : 1;
                        best  = above + 1;
                        if (dist_col[y - 1] + 1 < best)
                            best = dist_col[y - 1] + 1;
                        if (diag + cost < best)
                            best = diag + cost;
                        dist_col[y] = best;
                        diag = above;
                    end
                end
                else
                    overflow_seen = 1'b1;
            end
        endcase
        if (m == MODE_START || m == MODE_CAND)
        begin
            res.distance = 6'(dist_col[word_len]);
            res.overflow = overflow_seen;
            pending_distances.push_back(res);
        end
    endtask

    function automatic logic [7:0] pick_char();
        // small alphabet half the time so that matches happen
        if ($urandom_range(1))
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_item(input edd_mode_t m, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_distance(m, c);
        items_sent++;
    endtask

    // sender goes quiet until every expected result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reference of k characters, then n candidate characters mostly copied from it
    task automatic send_word_pair(input int k, input int n, input bit do_clear);
        logic [7:0] word [WORD_MAX + 3];
        if (do_clear)
            send_item(MODE_CLEAR, pick_char());
        for (int i = 0; i < k; i++)
        begin
            word[i] = pick_char();
            send_item(MODE_APPEND, word[i]);
        end
        send_item(MODE_START, pick_char());
        for (int j = 0; j < n; j++)
            send_item(MODE_CAND, (j < k && $urandom_range(9) < 7) ? word[j] : pick_char());
    endtask

    task automatic test_directed();
        send_item(MODE_CAND, 8'h71);     // no start after reset: column is all zero
        send_item(MODE_START, 8'hFF);    // empty reference
        send_item(MODE_CAND, 8'h00);
        send_item(MODE_CAND, 8'hFF);
        send_item(MODE_CLEAR, 8'hFF);
        send_item(MODE_APPEND, 8'h00);
        send_item(MODE_APPEND, 8'hFF);
        send_item(MODE_APPEND, 8'h6B);
        send_item(MODE_START, 8'hAA);
        send_item(MODE_CAND, 8'h00);
        send_item(MODE_CAND, 8'h80);
        send_item(MODE_CAND, 8'h6B);
        send_item(MODE_APPEND, 8'h7A);   // reference grows mid compare
        send_item(MODE_CAND, 8'h7A);
        send_item(MODE_CLEAR, 8'h00);
        send_item(MODE_CAND, 8'h55);     // stale column tail after clear
        send_item(MODE_APPEND, 8'h55);
        send_item(MODE_CAND, 8'h55);
        send_item(MODE_START, 8'h00);
        send_item(MODE_CAND, 8'h01);
        drain_results();
    endtask

    task automatic test_word_limits();
        // both words one past the limit: drops and sticky flag
        send_word_pair(WORD_MAX + 1, WORD_MAX + 1, 1'b1);
        send_item(MODE_START, pick_char());
        send_item(MODE_CAND, pick_char());
        send_word_pair(WORD_MAX, WORD_MAX, 1'b1);
        send_item(MODE_CAND, pick_char());
        send_item(MODE_CLEAR, pick_char());
        send_item(MODE_START, pick_char());
        drain_results();
    endtask

    task automatic test_random_words(input int n_items);
        int k;
        int n;
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                k = ($urandom_range(9) == 0) ? $urandom_range(WORD_MAX + 2) : $urandom_range(8);
                n = ($urandom_range(9) == 0) ? $urandom_range(WORD_MAX + 2) : $urandom_range(10);
                send_word_pair(k, n, $urandom_range(99) < 85);
            end
            else
                send_item(edd_mode_t'($urandom_range(3)), pick_char());
        end
    endtask

    task automatic test_output_stall();
        hold_left = 400;
        send_word_pair(6, 12, 1'b1);
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_word_pair(4, 5, 1'b1);
        drain_results();
        for (int i = 0; i < 6; i++)
            send_item(MODE_CAND, pick_char());
        drain_results();
    endtask

    // checks each output transfer, then picks the next tready
    always @(posedge clk)
    begin : result_monitor
        dist_result_t want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            results_seen++;
            if (pending_distances.size() == 0)
                report_failure("unexpected result", 0, m_axis_tdata);
            else
            begin
                want = pending_distances.pop_front();
                if (m_axis_tdata[5:0] !== want.distance)
                    report_failure("distance", want.distance, m_axis_tdata[5:0]);
                if (m_axis_tdata[6] !== want.overflow)
                    report_failure("overflow", want.overflow, m_axis_tdata[6]);
                if (m_axis_tdata[7] !== 1'b0)
                    report_failure("pad bit", 0, m_axis_tdata[7]);
            end
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        word_len      = 0;
        cand_len      = 0;
        overflow_seen = 1'b0;
        for (int z = 0; z <= WORD_MAX; z++)
            dist_col[z] = 0;
        send_idle_pct = 35;
        recv_idle_pct = 82;
        hold_left     = 0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_word_limits();
        test_random_words(130);
        test_output_stall();

        send_idle_pct = 82;
        recv_idle_pct = 35;
        test_random_words(130);
        test_sender_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_words(130);
        test_output_stall();
        drain_results();

        if (pending_distances.size() != 0)
            report_failure("missing results", 0, pending_distances.size());
        $display("%0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("covered all modes, word limit drops, sticky flag, output stalls, sender pauses");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/edd_pkg.sv
rtl/core/edd_ctrl.sv
rtl/core/edd_datapath.sv
rtl/core/edit_distance_engine.sv
bench/testbench.sv
